>>> sv/sdtq_pkg.sv
// Shared types and constants for the sorted deadline timer queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sdtq_pkg;

    // Field and state widths
    localparam int AMT_W  = 16;
    localparam int TAG_W  = 8;
    localparam int KIND_W = 2;
    localparam int NOW_W  = 17;   // clock plus one carry bit before wrap
    localparam int DL_W   = 18;   // signed deadline

    // Clock wrap period in ms
    localparam int WRAP_MS = 65000;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

    // Commands broadcast to every cell
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_WRAP   = 2'd2;
    localparam logic [1:0] OP_POP    = 2'd3;

    // One queue slot
    typedef struct packed {
        logic                    valid;
        logic signed [DL_W-1:0]  deadline;
        logic [TAG_W-1:0]        tag;
    } cell_t;

    // Control word from the sequencer to the cell row
    typedef struct packed {
        logic [1:0]              op;
        logic [NOW_W-1:0]        now;
        logic signed [DL_W-1:0]  new_deadline;
        logic [TAG_W-1:0]        new_tag;
    } ctl_t;

endpackage

>>> sv/sdtq_cell.sv
// One slot of the sorted timer row: holds a deadline and a tag.
// Depends on sdtq_pkg; instantiated CAPACITY times by the top level.
`timescale 1ns / 1ps

module sdtq_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  sdtq_pkg::ctl_t ctl,
    input  logic           prev_ins,
    input  sdtq_pkg::cell_t prev_cell,
    input  sdtq_pkg::cell_t next_cell,
    output sdtq_pkg::cell_t slot,
    output logic           ins,
    output logic           hit
);
    import sdtq_pkg::*;

    cell_t cell_reg;
    cell_t cell_next;

    // New timer belongs at or before this slot
    assign ins = !cell_reg.valid ||
                 ($signed(cell_reg.deadline) > $signed(ctl.new_deadline));
    // Timer in this slot due at the current clock
    assign hit = cell_reg.valid &&
                 ($signed({1'b0, ctl.now}) >= $signed(cell_reg.deadline));
    assign slot = cell_reg;

    // Select next slot contents
    always_comb begin
        cell_next = cell_reg;
        case (ctl.op)
            OP_INSERT: begin
                if (ins && prev_ins) begin
                    cell_next = prev_cell;
                end else if (ins) begin
                    cell_next.valid    = 1'b1;
                    cell_next.deadline = ctl.new_deadline;
                    cell_next.tag      = ctl.new_tag;
                end
            end
            OP_WRAP: begin
                cell_next.deadline = cell_reg.deadline - DL_W'(WRAP_MS);
            end
            OP_POP: begin
                cell_next = next_cell;
            end
            default: begin
            end
        endcase
    end

    // Load the slot; only the valid bit is reset
    always_ff @(posedge aclk) begin
        cell_reg.deadline <= cell_next.deadline;
        cell_reg.tag      <= cell_next.tag;
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else begin
            cell_reg.valid <= cell_next.valid;
        end
    end

endmodule

>>> sv/sorted_deadline_timer_queue.sv
// Top level of the sorted deadline timer queue: sequencer, clock and cell row.
// Depends on sdtq_pkg and sdtq_cell.
`timescale 1ns / 1ps
//
//  Channel | Ports                                   | Word
//  --------+-----------------------------------------+------------------------
//  in      | s_valid s_ready s_action s_amount s_tag | start or tick request
//  out     | m_valid m_ready m_kind m_tag_res m_last | one result per word
//
//  A start needs no extra step: the row inserts in place and the result is
//  registered, so starts run one every cycle while results drain freely.
//  A tick runs the accept, W clock wraps (0 to 2), each applied to the whole
//  row at once, the exit from the wrap step, then one popped timer per cycle
//  from the head while the output is free.
//  Output stalls hold the sequencer; no new word is taken until the last
//  result of the current one is registered. Reset empties the queue, zeroes
//  the clock and needs no clearing pass.

module sorted_deadline_timer_queue #(
    parameter int CAPACITY = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [sdtq_pkg::AMT_W-1:0]    s_amount,
    input  logic [sdtq_pkg::TAG_W-1:0]    s_tag,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sdtq_pkg::KIND_W-1:0]   m_kind,
    output logic [sdtq_pkg::TAG_W-1:0]    m_tag_res,
    output logic                          m_last
);
    import sdtq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WRAP = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [NOW_W-1:0]  now_reg, now_next;
    logic              m_valid_reg, m_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic              last_reg, last_next;

    ctl_t              ctl;
    cell_t             cell_q [0:CAPACITY];
    logic              ins_q  [0:CAPACITY-1];
    logic              hit_q  [0:CAPACITY];
    logic [NOW_W-1:0]  now_sum;
    logic              accept;
    logic              out_free;
    logic              full;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign now_sum  = now_reg + NOW_W'(s_amount);
    assign full     = cell_q[CAPACITY-1].valid;

    // Tie off the row ends
    assign cell_q[CAPACITY] = '0;
    assign hit_q[CAPACITY]  = 1'b0;

    // Row of slots, head at index 0
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_head
            sdtq_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .prev_ins  (1'b0),
                .prev_cell ('0),
                .next_cell (cell_q[i+1]),
                .slot      (cell_q[i]),
                .ins       (ins_q[i]),
                .hit       (hit_q[i])
            );
        end else begin : g_body
            sdtq_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .prev_ins  (ins_q[i-1]),
                .prev_cell (cell_q[i-1]),
                .next_cell (cell_q[i+1]),
                .slot      (cell_q[i]),
                .ins       (ins_q[i]),
                .hit       (hit_q[i])
            );
        end
    end

    // Sequence starts, wraps and pops
    always_comb begin
        state_next   = state_reg;
        now_next     = now_reg;
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        tag_next     = tag_reg;
        last_next    = last_reg;

        ctl.op           = OP_HOLD;
        ctl.now          = now_reg;
        ctl.new_deadline = $signed({1'b0, now_sum});
        ctl.new_tag      = s_tag;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action) begin
                        if (!full) begin
                            ctl.op = OP_INSERT;
                        end
                        m_valid_next = 1'b1;
                        kind_next    = full ? KIND_REJECT : KIND_ACCEPT;
                        tag_next     = s_tag;
                        last_next    = 1'b1;
                    end else begin
                        now_next   = now_sum;
                        state_next = ST_WRAP;
                    end
                end
            end
            ST_WRAP: begin
                if (now_reg >= NOW_W'(WRAP_MS)) begin
                    ctl.op   = OP_WRAP;
                    now_next = now_reg - NOW_W'(WRAP_MS);
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (hit_q[0]) begin
                        ctl.op    = OP_POP;
                        kind_next = KIND_EXPIRED;
                        tag_next  = cell_q[0].tag;
                        last_next = !hit_q[1];
                        if (!hit_q[1]) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        kind_next  = KIND_NONE;
                        tag_next   = '0;
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            now_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            now_reg     <= now_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result word
    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        tag_reg  <= tag_next;
        last_reg <= last_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_kind    = kind_reg;
    assign m_tag_res = tag_reg;
    assign m_last    = last_reg;

endmodule

>>> sv/sdtq_checker.sv
// Port-level checks for the sorted deadline timer queue, bound to the top level.
// Depends on sdtq_pkg and sorted_deadline_timer_queue.
`timescale 1ns / 1ps

module sdtq_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_action,
    input logic [sdtq_pkg::TAG_W-1:0]  s_tag,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [sdtq_pkg::KIND_W-1:0] m_kind,
    input logic [sdtq_pkg::TAG_W-1:0]  m_tag_res,
    input logic                        m_last
);
    import sdtq_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_tag_res)
        && $stable(m_last))
        else $error("result word changed while stalled");

    // Answer a start in the next cycle with its own tag
    a_start_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_action |=>
        m_valid && m_last && m_tag_res == $past(s_tag)
        && (m_kind == KIND_ACCEPT || m_kind == KIND_REJECT))
        else $error("start not answered in the next cycle");

    // Close every single-word answer
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_NONE || m_kind == KIND_ACCEPT
        || m_kind == KIND_REJECT) |-> m_last)
        else $error("single-word answer without last");

    // Drop the tag on an empty tick
    a_none_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_NONE |-> m_tag_res == '0)
        else $error("empty tick carries a tag");

endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (.*);
